@@ rtl/lpm_pkg.sv @@
// ----------------------------------------------------------------------------
// lpm_pkg
// shared constants, codes and control structs of the latency pair measurement
// ----------------------------------------------------------------------------
package lpm_pkg;

  // counter cycles per down-count step and nanoseconds per second
  localparam int unsigned CYCLES_PER_COUNT = 2;
  localparam logic [29:0] NS_PER_S         = 30'd1000000000;
  localparam logic [31:0] CLOCK_HZ_RST     = 32'd150000000;

  // widths of the latency arithmetic
  localparam int unsigned CYC_W = 32 + $clog2(CYCLES_PER_COUNT + 1);
  localparam int unsigned PLO_W = 62;
  localparam int unsigned NUM_W = CYC_W + 30;
  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  // input kinds
  localparam logic [2:0] K_TICK   = 3'd0;
  localparam logic [2:0] K_STIM   = 3'd1;
  localparam logic [2:0] K_CLICK  = 3'd2;
  localparam logic [2:0] K_MOTION = 3'd3;
  localparam logic [2:0] K_START  = 3'd4;
  localparam logic [2:0] K_STOP   = 3'd5;

  // result event kinds
  localparam logic [2:0] EV_MEAS     = 3'd0;
  localparam logic [2:0] EV_NO_RESP  = 3'd1;
  localparam logic [2:0] EV_DROP     = 3'd2;
  localparam logic [2:0] EV_MISORDER = 3'd3;
  localparam logic [2:0] EV_REARM    = 3'd4;

  // configuration register indexes
  localparam logic [2:0] CFG_STIM_RISING = 3'd0;
  localparam logic [2:0] CFG_AXIS_MODE   = 3'd1;
  localparam logic [2:0] CFG_HOLD_LEN    = 3'd2;
  localparam logic [2:0] CFG_RESP_LIMIT  = 3'd3;
  localparam logic [2:0] CFG_CLOCK_HZ    = 3'd4;

  typedef struct packed {
    logic       in_ready;
    logic       inc_timeout;
    logic       inc_drop;
    logic       inc_stray;
    logic       inc_order;
    logic       inc_good;
    logic       set_pending;
    logic       begin_hold;
    logic       clr_hold;
    logic       emit;
    logic [2:0] emit_kind;
    logic       emit_resp;
    logic       emit_meas;
    logic       mul_start;
    logic       mul_step;
    logic       div_start;
  } lpm_cmd_t;

  typedef struct packed {
    logic       in_fire;
    logic [2:0] kind;
    logic       timeout_hit;
    logic       hold_expired;
    logic       at_rest;
    logic       order_err;
    logic       chan_match;
    logic       cfg_hit;
    logic       out_free;
    logic       div_done;
  } lpm_sts_t;

endpackage

@@ rtl/lpm_if.sv @@
// ----------------------------------------------------------------------------
// lpm_in_if / lpm_out_if
// valid/ready channels carrying input words and result words
// ----------------------------------------------------------------------------
interface lpm_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] stamp;
  logic [31:0] now_us;
  logic        stim_level;

  modport source (output valid, kind, stamp, now_us, stim_level, input ready);
  modport sink   (input valid, kind, stamp, now_us, stim_level, output ready);
endinterface

interface lpm_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_kind;
  logic        axis;
  logic [31:0] sequence_res;
  logic [31:0] stim_stamp;
  logic [31:0] resp_stamp;
  logic [31:0] latency_ns;
  logic [31:0] timeout_count;
  logic [31:0] drop_count;
  logic [31:0] stray_count;
  logic [31:0] order_count;
  logic [31:0] axis_sequence;

  modport source (output valid, event_kind, axis, sequence_res, stim_stamp, resp_stamp,
                  latency_ns, timeout_count, drop_count, stray_count, order_count,
                  axis_sequence, input ready);
  modport sink   (input valid, event_kind, axis, sequence_res, stim_stamp, resp_stamp,
                  latency_ns, timeout_count, drop_count, stray_count, order_count,
                  axis_sequence, output ready);
endinterface

@@ rtl/lpm_div.sv @@
// ----------------------------------------------------------------------------
// lpm_div
// restoring divider, one quotient bit per cycle, low 32 quotient bits kept
// ----------------------------------------------------------------------------
module lpm_div import lpm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [31:0]      den_i,
  output logic             done_o,
  output logic [31:0]      quo_o
);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0] num_q, num_d;
  logic [31:0]      rem_q, rem_d;
  logic [31:0]      quo_q, quo_d;
  logic [32:0]      rem_sh;
  logic [32:0]      rem_sub;
  logic             ge;

  assign rem_sh  = {rem_q, num_q[NUM_W-1]};
  assign ge      = rem_sh >= {1'b0, den_i};
  assign rem_sub = rem_sh - {1'b0, den_i};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(NUM_W);
      num_d  = num_i;
      rem_d  = '0;
      quo_d  = '0;
    end else if (busy_q) begin
      rem_d = ge ? rem_sub[31:0] : rem_sh[31:0];
      quo_d = {quo_q[30:0], ge};
      num_d = {num_q[NUM_W-2:0], 1'b0};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

@@ rtl/lpm_datapath.sv @@
// ----------------------------------------------------------------------------
// lpm_datapath
// configuration, stamps, counters, latency arithmetic and the result register
// ----------------------------------------------------------------------------
module lpm_datapath import lpm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  lpm_in_if.sink      in_i,
  lpm_out_if.source   out_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  lpm_cmd_t    cmd_i,
  output lpm_sts_t    sts_o
);

  // configuration
  logic        stim_rising_q;
  logic        axis_mode_q;
  logic [31:0] hold_len_q;
  logic [31:0] resp_limit_q;
  logic [31:0] clock_hz_q;

  // captured input word
  logic [2:0]  kind_q;
  logic [31:0] stamp_q;
  logic [31:0] now_q;
  logic        level_q;

  // measurement state
  logic [31:0] pending_q, entered_q, hold_until_q;
  logic [31:0] good_q, timeouts_q, drops_q, strays_q, orders_q;
  logic [31:0] good_d, timeouts_d, drops_d, strays_d, orders_d;
  logic [31:0] per_axis_q [2];
  logic [31:0] per_axis_d [2];

  // latency arithmetic
  logic [CYC_W-1:0] cyc_q;
  logic [PLO_W-1:0] plo_q;
  logic [NUM_W-1:0] num;
  logic [31:0]      den;
  logic [31:0]      quo;
  logic             div_done;

  logic        in_fire;
  logic        out_v_q;
  logic        out_free;
  logic [31:0] diff;
  logic [31:0] to_elapsed;
  logic [31:0] hold_elapsed;

  assign in_fire    = in_i.valid && cmd_i.in_ready;
  assign in_i.ready = cmd_i.in_ready;

  assign diff         = pending_q - stamp_q;
  assign to_elapsed   = now_q - entered_q;
  assign hold_elapsed = now_q - hold_until_q;
  assign out_free     = !out_v_q || out_o.ready;

  always_comb begin
    sts_o.in_fire      = in_fire;
    sts_o.kind         = kind_q;
    sts_o.timeout_hit  = to_elapsed > resp_limit_q;
    sts_o.hold_expired = !hold_elapsed[31];
    sts_o.at_rest      = level_q != stim_rising_q;
    sts_o.order_err    = (stamp_q > pending_q) || diff[31];
    sts_o.chan_match   = (kind_q == K_MOTION) == axis_mode_q;
    sts_o.cfg_hit      = cfg_we_i && (cfg_idx_i inside {[CFG_STIM_RISING:CFG_CLOCK_HZ]});
    sts_o.out_free     = out_free;
    sts_o.div_done     = div_done;
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stim_rising_q <= 1'b1;
      axis_mode_q   <= 1'b0;
      hold_len_q    <= '0;
      resp_limit_q  <= '0;
      clock_hz_q    <= CLOCK_HZ_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_STIM_RISING: stim_rising_q <= cfg_wdata_i[0];
        CFG_AXIS_MODE:   axis_mode_q   <= cfg_wdata_i[0];
        CFG_HOLD_LEN:    hold_len_q    <= cfg_wdata_i;
        CFG_RESP_LIMIT:  resp_limit_q  <= cfg_wdata_i;
        CFG_CLOCK_HZ:    clock_hz_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q  <= in_i.kind;
      stamp_q <= in_i.stamp;
      now_q   <= in_i.now_us;
      level_q <= in_i.stim_level;
    end
  end

  // counters, all wrap
  always_comb begin
    good_d        = good_q + 32'(cmd_i.inc_good);
    timeouts_d    = timeouts_q + 32'(cmd_i.inc_timeout);
    drops_d       = drops_q + 32'(cmd_i.inc_drop);
    strays_d      = strays_q + 32'(cmd_i.inc_stray);
    orders_d      = orders_q + 32'(cmd_i.inc_order);
    per_axis_d[0] = per_axis_q[0];
    per_axis_d[1] = per_axis_q[1];
    per_axis_d[axis_mode_q] = per_axis_q[axis_mode_q] + 32'(cmd_i.inc_good);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      good_q        <= '0;
      timeouts_q    <= '0;
      drops_q       <= '0;
      strays_q      <= '0;
      orders_q      <= '0;
      per_axis_q[0] <= '0;
      per_axis_q[1] <= '0;
      pending_q     <= '0;
      entered_q     <= '0;
      hold_until_q  <= '0;
    end else begin
      good_q        <= good_d;
      timeouts_q    <= timeouts_d;
      drops_q       <= drops_d;
      strays_q      <= strays_d;
      orders_q      <= orders_d;
      per_axis_q[0] <= per_axis_d[0];
      per_axis_q[1] <= per_axis_d[1];
      if (cmd_i.set_pending) begin
        pending_q <= stamp_q;
        entered_q <= now_q;
      end
      if (cmd_i.begin_hold) begin
        hold_until_q <= now_q + hold_len_q;
      end else if (cmd_i.clr_hold) begin
        hold_until_q <= '0;
      end
    end
  end

  // latency: floor(diff * cycles * 1e9 / clock_hz), product split in two halves
  assign num = NUM_W'(plo_q) + ((NUM_W'(cyc_q[CYC_W-1:32]) * NUM_W'(NS_PER_S)) << 32);
  assign den = (clock_hz_q == '0) ? 32'd1 : clock_hz_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_start) begin
      cyc_q <= CYC_W'(diff) * CYC_W'(CYCLES_PER_COUNT);
    end
    if (cmd_i.mul_step) begin
      plo_q <= PLO_W'(cyc_q[31:0]) * PLO_W'(NS_PER_S);
    end
  end

  lpm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (num),
    .den_i   (den),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // result register, loaded with post-update counter values
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (cmd_i.emit || cmd_i.emit_meas) begin
      out_v_q <= 1'b1;
    end else if (out_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit || cmd_i.emit_meas) begin
      out_o.event_kind    <= cmd_i.emit_meas ? EV_MEAS : cmd_i.emit_kind;
      out_o.axis          <= axis_mode_q;
      out_o.sequence_res  <= good_d;
      out_o.stim_stamp    <= pending_q;
      out_o.resp_stamp    <= (cmd_i.emit_meas || cmd_i.emit_resp) ? stamp_q : 32'd0;
      out_o.latency_ns    <= cmd_i.emit_meas ? quo : 32'd0;
      out_o.timeout_count <= timeouts_d;
      out_o.drop_count    <= drops_d;
      out_o.stray_count   <= strays_d;
      out_o.order_count   <= orders_d;
      out_o.axis_sequence <= per_axis_d[axis_mode_q];
    end
  end

  assign out_o.valid = out_v_q;

endmodule

@@ rtl/lpm_ctrl.sv @@
// ----------------------------------------------------------------------------
// lpm_ctrl
// measurement phase machine and item sequencer
// ----------------------------------------------------------------------------
module lpm_ctrl import lpm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  lpm_sts_t sts_i,
  output lpm_cmd_t cmd_o
);

  // sequencer states
  localparam logic [2:0] C_IDLE = 3'd0;
  localparam logic [2:0] C_EXEC = 3'd1;
  localparam logic [2:0] C_MUL1 = 3'd2;
  localparam logic [2:0] C_MUL2 = 3'd3;
  localparam logic [2:0] C_DIV  = 3'd4;

  // measurement phases
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_ARMED = 2'd1;
  localparam logic [1:0] PH_SEEN  = 2'd2;
  localparam logic [1:0] PH_HOLD  = 2'd3;

  logic [2:0] state_q, state_d;
  logic [1:0] ph_q, ph_d;
  logic       en_q, en_d;
  logic       rearm_q, rearm_d;

  always_comb begin
    state_d = state_q;
    ph_d    = ph_q;
    en_d    = en_q;
    rearm_d = rearm_q;
    cmd_o   = '0;
    cmd_o.in_ready = (state_q == C_IDLE);

    case (state_q)
      C_IDLE: begin
        if (sts_i.in_fire) begin
          state_d = C_EXEC;
        end else if (sts_i.cfg_hit) begin
          // a write to a defined register index drops any pending stimulus
          if (en_q) begin
            ph_d    = PH_HOLD;
            rearm_d = 1'b1;
          end else begin
            ph_d = PH_IDLE;
          end
        end
      end
      C_EXEC: begin
        // wait until the result register can take a word
        if (sts_i.out_free) begin
          state_d = C_IDLE;
          case (sts_i.kind)
            K_TICK: begin
              if (en_q && ph_q == PH_SEEN && sts_i.timeout_hit) begin
                cmd_o.inc_timeout = 1'b1;
                cmd_o.begin_hold  = 1'b1;
                cmd_o.emit        = 1'b1;
                cmd_o.emit_kind   = EV_NO_RESP;
                ph_d    = PH_HOLD;
                rearm_d = 1'b0;
              end else if (en_q && ph_q == PH_HOLD && (rearm_q || sts_i.hold_expired)
                           && sts_i.at_rest) begin
                cmd_o.clr_hold  = 1'b1;
                cmd_o.emit      = 1'b1;
                cmd_o.emit_kind = EV_REARM;
                ph_d    = PH_ARMED;
                rearm_d = 1'b0;
              end
            end
            K_STIM: begin
              if (ph_q == PH_ARMED) begin
                cmd_o.set_pending = 1'b1;
                ph_d = PH_SEEN;
              end else if (ph_q == PH_SEEN) begin
                cmd_o.inc_drop    = 1'b1;
                cmd_o.emit        = 1'b1;
                cmd_o.emit_kind   = EV_DROP;
                cmd_o.set_pending = 1'b1;
              end
            end
            K_CLICK, K_MOTION: begin
              if (sts_i.chan_match) begin
                if (ph_q != PH_SEEN) begin
                  cmd_o.inc_stray = 1'b1;
                end else if (sts_i.order_err) begin
                  cmd_o.inc_order  = 1'b1;
                  cmd_o.begin_hold = 1'b1;
                  cmd_o.emit       = 1'b1;
                  cmd_o.emit_kind  = EV_MISORDER;
                  cmd_o.emit_resp  = 1'b1;
                  ph_d    = PH_HOLD;
                  rearm_d = 1'b0;
                end else begin
                  cmd_o.inc_good   = 1'b1;
                  cmd_o.begin_hold = 1'b1;
                  cmd_o.mul_start  = 1'b1;
                  ph_d    = PH_HOLD;
                  rearm_d = 1'b0;
                  state_d = C_MUL1;
                end
              end
            end
            K_START: begin
              en_d    = 1'b1;
              ph_d    = PH_HOLD;
              rearm_d = 1'b1;
            end
            K_STOP: begin
              en_d = 1'b0;
              ph_d = PH_IDLE;
            end
            default: ;
          endcase
        end
      end
      C_MUL1: begin
        cmd_o.mul_step = 1'b1;
        state_d = C_MUL2;
      end
      C_MUL2: begin
        cmd_o.div_start = 1'b1;
        state_d = C_DIV;
      end
      C_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.emit_meas = 1'b1;
          state_d = C_IDLE;
        end
      end
      default: begin
        state_d = C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      ph_q    <= PH_IDLE;
      en_q    <= 1'b0;
      rearm_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ph_q    <= ph_d;
      en_q    <= en_d;
      rearm_q <= rearm_d;
    end
  end

  a_emit_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit || cmd_o.emit_meas) |-> sts_i.out_free)
    else $error("result word loaded while the result register is full");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> (state_q == C_DIV))
    else $error("divider finished outside the divide state");

  a_disabled_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_q |-> (ph_q == PH_IDLE))
    else $error("measurement phase active while disabled");

  a_meas_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == C_MUL1) |-> (ph_q == PH_HOLD))
    else $error("latency arithmetic running outside holdoff");

endmodule

@@ rtl/latency_pair_measure_fsm_core.sv @@
// ----------------------------------------------------------------------------
// latency_pair_measure_fsm_core
// pairs stimulus and response edge stamps and reports latency in nanoseconds
// ----------------------------------------------------------------------------
//  channel   direction  handshake      word
//  in_i      sink       valid/ready    kind, stamp, now_us, stim_level
//  out_o     source     valid/ready    event_kind ... axis_sequence
//  cfg       write      cfg_we_i       cfg_idx_i, cfg_wdata_i
//
//  a word without a measurement returns from execute to idle for the next accept
//  a measurement runs execute, MUL1, MUL2 and the divide state, the last
//  paced by the one-bit-per-cycle restoring divider
//  a full result register holds the next word in execute until it drains
//  asynchronous active-low reset, no clearing pass
// ----------------------------------------------------------------------------
module latency_pair_measure_fsm_core import lpm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  lpm_in_if.sink      in_i,
  lpm_out_if.source   out_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);

  lpm_cmd_t cmd;
  lpm_sts_t sts;

  lpm_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  lpm_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_o       (out_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

@@ bench/tb_latency_pair_measure_fsm_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_latency_pair_measure_fsm_core
// self-checking bench: drives edge, tick and control words through the input
// channel, predicts every outcome word in a scoreboard and compares it field
// by field, under several register settings and idle/stall patterns
// ----------------------------------------------------------------------------
module tb_latency_pair_measure_fsm_core;
  import lpm_pkg::*;

  localparam logic [31:0] REARM_BASE    = 32'h8000_0000;
  localparam logic [31:0] MAX_FWD_DIFF  = 32'h7FFF_FFFF;
  localparam logic [2:0]  K_SPARE_LO    = 3'd6;
  localparam logic [2:0]  K_SPARE_HI    = 3'd7;
  localparam logic [2:0]  CFG_IDX_MAX   = 3'd7;
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam int unsigned STALL_LIMIT   = 3000;
  localparam int unsigned NUM_PHASES    = 12;
  localparam int unsigned WORDS_PER_PH  = 112;
  localparam int unsigned MAX_REPORTS   = 10;

  typedef enum logic [1:0] {PH_IDLE, PH_ARMED, PH_SEEN, PH_HOLD} phase_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] stamp;
    logic [31:0] now_us;
    logic        stim_level;
  } word_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic        axis;
    logic [31:0] sequence_res;
    logic [31:0] stim_stamp;
    logic [31:0] resp_stamp;
    logic [31:0] latency_ns;
    logic [31:0] timeout_count;
    logic [31:0] drop_count;
    logic [31:0] stray_count;
    logic [31:0] order_count;
    logic [31:0] axis_sequence;
  } outcome_t;

  // mirror of the pairing machine plus the queue of outcomes still owed
  class lpm_scoreboard;
    bit          stim_rising;
    bit          axis_mode;
    bit [31:0]   hold_len;
    bit [31:0]   resp_limit;
    bit [31:0]   clock_hz;
    phase_e      phase;
    bit          enabled;
    bit [31:0]   pending_stim;
    bit [31:0]   entered_at;
    bit [31:0]   holdoff_until;
    bit          rearm_now;
    bit [31:0]   good_total;
    bit [31:0]   good_per_axis[2];
    bit [31:0]   timeouts;
    bit [31:0]   drops;
    bit [31:0]   strays;
    bit [31:0]   order_errors;
    outcome_t    due[$];
    int unsigned fail_count;

    function new();
      stim_rising      = 1'b1;
      axis_mode        = 1'b0;
      hold_len         = '0;
      resp_limit       = '0;
      clock_hz         = CLOCK_HZ_RST;
      phase            = PH_IDLE;
      enabled          = 1'b0;
      pending_stim     = '0;
      entered_at       = '0;
      holdoff_until    = '0;
      rearm_now        = 1'b0;
      good_total       = '0;
      good_per_axis[0] = '0;
      good_per_axis[1] = '0;
      timeouts         = '0;
      drops            = '0;
      strays           = '0;
      order_errors     = '0;
      fail_count       = 0;
    endfunction

    function bit [31:0] latency_of(bit [31:0] d);
      longint unsigned hz, cyc, q, r, ns_s;
      ns_s = 64'(NS_PER_S);
      hz   = (clock_hz == 0) ? 64'd1 : 64'(clock_hz);
      cyc  = 64'(d) * 64'(CYCLES_PER_COUNT);
      q    = cyc / hz;
      r    = cyc % hz;
      return 32'(q * ns_s + (r * ns_s) / hz);
    endfunction

    function void owe(logic [2:0] kind, bit [31:0] resp, bit [31:0] lat);
      outcome_t e;
      e.event_kind    = kind;
      e.axis          = axis_mode;
      e.sequence_res  = good_total;
      e.stim_stamp    = pending_stim;
      e.resp_stamp    = resp;
      e.latency_ns    = lat;
      e.timeout_count = timeouts;
      e.drop_count    = drops;
      e.stray_count   = strays;
      e.order_count   = order_errors;
      e.axis_sequence = good_per_axis[axis_mode];
      due.push_back(e);
    endfunction

    function void start_holdoff(bit [31:0] now);
      phase         = PH_HOLD;
      holdoff_until = now + hold_len;
      rearm_now     = 1'b0;
    endfunction

    function void apply_cfg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        CFG_STIM_RISING: stim_rising = data[0];
        CFG_AXIS_MODE:   axis_mode   = data[0];
        CFG_HOLD_LEN:    hold_len    = data;
        CFG_RESP_LIMIT:  resp_limit  = data;
        CFG_CLOCK_HZ:    clock_hz    = data;
        default:         return;
      endcase
      if (enabled) begin
        phase     = PH_HOLD;
        rearm_now = 1'b1;
      end else begin
        phase = PH_IDLE;
      end
    endfunction

    function void note_word(word_t w);
      bit [31:0] d;
      case (w.kind)
        K_TICK: begin
          if (enabled && phase == PH_SEEN && 32'(w.now_us - entered_at) > resp_limit) begin
            timeouts++;
            start_holdoff(w.now_us);
            owe(EV_NO_RESP, '0, '0);
          end else if (enabled && phase == PH_HOLD &&
                       (rearm_now || 32'(w.now_us - holdoff_until) < REARM_BASE) &&
                       w.stim_level == !stim_rising) begin
            phase         = PH_ARMED;
            rearm_now     = 1'b0;
            holdoff_until = '0;
            owe(EV_REARM, '0, '0);
          end
        end
        K_STIM: begin
          if (phase == PH_ARMED) begin
            pending_stim = w.stamp;
            entered_at   = w.now_us;
            phase        = PH_SEEN;
          end else if (phase == PH_SEEN) begin
            // the dropped word still carries the old stamp
            drops++;
            owe(EV_DROP, '0, '0);
            pending_stim = w.stamp;
            entered_at   = w.now_us;
          end
        end
        K_CLICK, K_MOTION: begin
          if (w.kind[0] == axis_mode) begin
            if (phase != PH_SEEN) begin
              strays++;
            end else if (w.stamp > pending_stim ||
                         32'(pending_stim - w.stamp) > MAX_FWD_DIFF) begin
              order_errors++;
              start_holdoff(w.now_us);
              owe(EV_MISORDER, w.stamp, '0);
            end else begin
              d = pending_stim - w.stamp;
              good_total++;
              good_per_axis[axis_mode]++;
              start_holdoff(w.now_us);
              owe(EV_MEAS, w.stamp, latency_of(d));
            end
          end
        end
        K_START: begin
          enabled   = 1'b1;
          phase     = PH_HOLD;
          rearm_now = 1'b1;
        end
        K_STOP: begin
          enabled = 1'b0;
          phase   = PH_IDLE;
        end
        default: ;
      endcase
    endfunction

    function string show(outcome_t e);
      return $sformatf({"kind %0d axis %0d seq %0d stim %h resp %h lat %0d",
                        " to %0d drop %0d stray %0d order %0d axseq %0d"},
                       e.event_kind, e.axis, e.sequence_res, e.stim_stamp, e.resp_stamp,
                       e.latency_ns, e.timeout_count, e.drop_count, e.stray_count,
                       e.order_count, e.axis_sequence);
    endfunction

    function void check_event(outcome_t got);
      outcome_t want;
      string    bad;
      if (due.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("unexpected result word: %s", show(got));
        return;
      end
      want = due.pop_front();
      bad  = "";
      if (got.event_kind    !== want.event_kind)    bad = {bad, " event_kind"};
      if (got.axis          !== want.axis)          bad = {bad, " axis"};
      if (got.sequence_res  !== want.sequence_res)  bad = {bad, " sequence_res"};
      if (got.stim_stamp    !== want.stim_stamp)    bad = {bad, " stim_stamp"};
      if (got.resp_stamp    !== want.resp_stamp)    bad = {bad, " resp_stamp"};
      if (got.latency_ns    !== want.latency_ns)    bad = {bad, " latency_ns"};
      if (got.timeout_count !== want.timeout_count) bad = {bad, " timeout_count"};
      if (got.drop_count    !== want.drop_count)    bad = {bad, " drop_count"};
      if (got.stray_count   !== want.stray_count)   bad = {bad, " stray_count"};
      if (got.order_count   !== want.order_count)   bad = {bad, " order_count"};
      if (got.axis_sequence !== want.axis_sequence) bad = {bad, " axis_sequence"};
      if (bad != "") begin
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
          $display("result mismatch in%s", bad);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [31:0] cfg_wdata_i;

  lpm_in_if  in_bus();
  lpm_out_if out_bus();

  lpm_scoreboard sb;
  int unsigned   send_idle_pct = 0;
  int unsigned   stall_pct     = 0;
  int unsigned   quiet_cycles  = 0;
  logic [31:0]   clock_us      = '0;

  latency_pair_measure_fsm_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_bus),
    .out_o       (out_bus),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_bus.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      sb.check_event('{out_bus.event_kind, out_bus.axis, out_bus.sequence_res,
                       out_bus.stim_stamp, out_bus.resp_stamp, out_bus.latency_ns,
                       out_bus.timeout_count, out_bus.drop_count, out_bus.stray_count,
                       out_bus.order_count, out_bus.axis_sequence});
    end
  end

  // watchdog on cycles where no word moves on either channel
  always @(posedge clk_i) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic put_word(input word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_bus.valid      <= 1'b1;
    in_bus.kind       <= w.kind;
    in_bus.stamp      <= w.stamp;
    in_bus.now_us     <= w.now_us;
    in_bus.stim_level <= w.stim_level;
    do @(posedge clk_i); while (!in_bus.ready);
    sb.note_word(w);
  endtask

  task automatic drain_results();
    in_bus.valid <= 1'b0;
    do @(posedge clk_i); while (sb.due.size() != 0);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    drain_results();
    // words with no outcome may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.apply_cfg(idx, data);
  endtask

  task automatic set_config(input int unsigned p);
    logic [31:0] hold, tmo, hz;
    case (p % 4)
      0:       hold = '0;
      1:       hold = '1;
      2:       hold = $urandom_range(2000, 1);
      default: hold = $urandom;
    endcase
    case ((p + 1) % 4)
      0:       tmo = '0;
      1:       tmo = '1;
      2:       tmo = $urandom_range(3000, 1);
      default: tmo = $urandom;
    endcase
    case (p % 5)
      0:       hz = CLOCK_HZ_RST;
      1:       hz = '0;
      2:       hz = 32'd1;
      3:       hz = '1;
      default: hz = $urandom;
    endcase
    write_reg(3'($urandom_range(CFG_IDX_MAX, CFG_CLOCK_HZ + 1)), $urandom);
    write_reg(CFG_STIM_RISING, {31'($urandom), 1'(p % 2)});
    write_reg(CFG_AXIS_MODE, {31'($urandom), 1'((p / 2) % 2)});
    write_reg(CFG_HOLD_LEN, hold);
    write_reg(CFG_RESP_LIMIT, tmo);
    write_reg(CFG_CLOCK_HZ, hz);
  endtask

  // mostly well-formed trials steered by the predicted phase, some noise
  function automatic word_t next_word();
    word_t       w;
    int unsigned roll;
    clock_us     = clock_us + $urandom_range(40, 1);
    w.kind       = K_TICK;
    w.stamp      = $urandom;
    w.now_us     = clock_us;
    w.stim_level = 1'($urandom_range(1));
    roll         = $urandom_range(99);
    if (roll < 12) begin
      w.kind = 3'($urandom_range(7));
      if ($urandom_range(3) == 0) begin
        clock_us = $urandom;
        w.now_us = clock_us;
      end
      return w;
    end
    case (sb.phase)
      PH_IDLE: w.kind = ($urandom_range(9) == 0) ? K_TICK : K_START;
      PH_HOLD: begin
        if (!sb.rearm_now && $urandom_range(9) < 7) begin
          clock_us = sb.holdoff_until + $urandom_range(500);
          w.now_us = clock_us;
        end
        w.stim_level = ($urandom_range(9) < 8) ? !sb.stim_rising : sb.stim_rising;
      end
      PH_ARMED: begin
        w.kind  = ($urandom_range(9) == 0) ? K_TICK : K_STIM;
        w.stamp = REARM_BASE - $urandom_range(100000);
      end
      default: begin
        roll = $urandom_range(99);
        if (roll < 60) begin
          w.kind = sb.axis_mode ? K_MOTION : K_CLICK;
          case ($urandom_range(19))
            0:       w.stamp = sb.pending_stim;
            1:       w.stamp = sb.pending_stim + $urandom_range(1000, 1);
            2:       w.stamp = $urandom;
            3:       w.stamp = sb.pending_stim - MAX_FWD_DIFF;
            4:       w.stamp = sb.pending_stim - REARM_BASE;
            default: w.stamp = sb.pending_stim - $urandom_range(300000);
          endcase
        end else if (roll < 75) begin
          if ($urandom_range(1) == 0) begin
            clock_us = sb.entered_at + sb.resp_limit + $urandom_range(2);
            w.now_us = clock_us;
          end
        end else if (roll < 85) begin
          w.kind  = K_STIM;
          w.stamp = sb.pending_stim - $urandom_range(5000);
        end else if (roll < 95) begin
          w.kind = sb.axis_mode ? K_CLICK : K_MOTION;
        end else begin
          w.kind = K_STOP;
        end
      end
    endcase
    return w;
  endfunction

  initial begin
    int unsigned p, n;
    sb = new();
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_idx_i         <= '0;
    cfg_wdata_i       <= '0;
    in_bus.valid      <= 1'b0;
    in_bus.kind       <= K_TICK;
    in_bus.stamp      <= '0;
    in_bus.now_us     <= '0;
    in_bus.stim_level <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset settings, rising stimulus, click channel, zero timeout
    put_word('{K_TICK, 32'h0, 32'd0, 1'b0});            // disabled, nothing
    put_word('{K_CLICK, 32'h0, 32'd1, 1'b0});           // stray
    put_word('{K_MOTION, 32'hFFFF_FFFF, 32'd2, 1'b1});  // idle channel
    put_word('{K_STIM, 32'h1234_5678, 32'd3, 1'b1});    // stimulus while idle
    put_word('{K_SPARE_LO, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1});
    put_word('{K_SPARE_HI, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1});
    put_word('{K_START, 32'h0, 32'd10, 1'b0});
    put_word('{K_TICK, 32'h0, 32'd11, 1'b1});           // pin not at rest
    put_word('{K_TICK, 32'h0, 32'd12, 1'b0});           // rearm
    put_word('{K_STIM, REARM_BASE, 32'd100, 1'b0});
    put_word('{K_STIM, 32'h7FFF_FFF0, 32'd100, 1'b0}); // second stimulus
    put_word('{K_CLICK, 32'h7FFF_FFF0, 32'd100, 1'b0}); // equal stamp, zero latency
    put_word('{K_TICK, 32'h0, 32'd100, 1'b0});
    put_word('{K_STIM, 32'hFFFF_FFFF, 32'd200, 1'b0});
    put_word('{K_CLICK, 32'h7FFF_FFFF, 32'd201, 1'b0}); // too far apart
    put_word('{K_TICK, 32'h0, 32'd300, 1'b0});
    put_word('{K_STIM, 32'hFFFF_FFFF, 32'd301, 1'b0});
    put_word('{K_CLICK, REARM_BASE, 32'd302, 1'b0});    // widest legal gap
    put_word('{K_TICK, 32'h0, 32'd400, 1'b0});
    put_word('{K_STIM, 32'd5, 32'd401, 1'b0});
    put_word('{K_CLICK, 32'd6, 32'd402, 1'b0});         // response stamp later
    put_word('{K_TICK, 32'h0, 32'd500, 1'b0});
    put_word('{K_STIM, REARM_BASE, 32'd1000, 1'b0});
    put_word('{K_TICK, 32'h0, 32'd1000, 1'b0});         // exactly at the timeout
    put_word('{K_TICK, 32'h0, 32'd1001, 1'b0});         // past it
    put_word('{K_STOP, 32'h0, 32'd1002, 1'b0});
    clock_us = 32'd2000;

    for (p = 0; p < NUM_PHASES; p++) begin
      set_config(p);
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 84; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 84; end
        default: begin send_idle_pct = 28; stall_pct = 28; end
      endcase
      for (n = 0; n < WORDS_PER_PH; n++) begin
        if (n == WORDS_PER_PH / 2) drain_results();
        put_word(next_word());
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    sb.fail_count += sb.due.size();
    if (sb.fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
